### hdl/lcgja_pkg.sv
`timescale 1ns / 1ps
// lcgja_pkg: types, constants and register codes for the lcg jump-ahead block
// no dependencies; used by the interfaces, controller, datapath and top level

package lcgja_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [WORD_W-1:0] MULT_RESET = 32'd214013;
    localparam logic [WORD_W-1:0] INC_RESET  = 32'd2531011;

    localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 8'd1;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_AM   = 3'd1,
        OP_AA   = 3'd2,
        OP_CA   = 3'd3,
        OP_CM   = 3'd4,
        OP_FIN  = 3'd5
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic k_zero;
        logic k_lsb;
        logic k_more;
        logic k_next_lsb;
    } t_dp_sts;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        t_word                data;
    } t_cfg_wr;

endpackage

### hdl/lcgja_if.sv
`timescale 1ns / 1ps
// lcgja_if: valid/ready channel interfaces for input, result and config writes
// depends on lcgja_pkg

interface lcgja_in_if;
    logic                  valid;
    logic                  ready;
    lcgja_pkg::t_word      seed_in;
    lcgja_pkg::t_word      step_count;

    modport source (output valid, output seed_in, output step_count, input ready);
    modport sink   (input valid, input seed_in, input step_count, output ready);
endinterface

interface lcgja_out_if;
    logic                  valid;
    logic                  ready;
    lcgja_pkg::t_word      seed_out;

    modport source (output valid, output seed_out, input ready);
    modport sink   (input valid, input seed_out, output ready);
endinterface

interface lcgja_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [lcgja_pkg::CFG_IDX_W-1:0]      index;
    lcgja_pkg::t_word                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/lcgja_ctrl.sv
`timescale 1ns / 1ps
// lcgja_ctrl: one-hot sequencer that walks the count bits and issues datapath ops
// depends on lcgja_pkg

module lcgja_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lcgja_pkg::t_dp_cmd o_cmd,
    input  lcgja_pkg::t_dp_sts i_sts
);
    import lcgja_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_BIT  = 7'b0000010,
        S_AM   = 7'b0000100,
        S_AA   = 7'b0001000,
        S_CA   = 7'b0010000,
        S_CM   = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd.load  = 1'b0;
        o_cmd.op    = OP_NONE;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BIT;
                end
            end
            S_BIT: begin
                if (i_sts.k_zero) begin
                    n_state = S_FIN;
                end else if (i_sts.k_lsb) begin
                    n_state = S_AM;
                end else begin
                    n_state = S_CA;
                end
            end
            S_AM: begin
                o_cmd.op = OP_AM;
                n_state  = S_AA;
            end
            S_AA: begin
                o_cmd.op = OP_AA;
                n_state  = S_CA;
            end
            S_CA: begin
                o_cmd.op = OP_CA;
                n_state  = S_CM;
            end
            S_CM: begin
                o_cmd.op = OP_CM;
                if (!i_sts.k_more) begin
                    n_state = S_FIN;
                end else if (i_sts.k_next_lsb) begin
                    n_state = S_AM;
                end else begin
                    n_state = S_CA;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    o_cmd.op    = OP_FIN;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/lcgja_dp.sv
`timescale 1ns / 1ps
// lcgja_dp: config registers, accumulators, count shifter and one shared multiplier
// depends on lcgja_pkg

module lcgja_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcgja_pkg::t_cfg_wr i_cfg,
    input  lcgja_pkg::t_dp_cmd i_cmd,
    output lcgja_pkg::t_dp_sts o_sts,
    input  lcgja_pkg::t_word   i_seed_in,
    input  lcgja_pkg::t_word   i_step_count,
    output lcgja_pkg::t_word   o_seed_out
);
    import lcgja_pkg::*;

    t_word r_multiplier;
    t_word r_increment;
    t_word r_acc_mul;
    t_word r_acc_add;
    t_word r_cur_mul;
    t_word r_cur_add;
    t_word r_k;
    t_word r_seed;
    t_word r_seed_out;

    t_word w_opa;
    t_word w_opb;
    t_word w_addend;
    t_word w_result;

    always_comb begin
        w_opa    = r_acc_mul;
        w_opb    = r_cur_mul;
        w_addend = '0;
        case (i_cmd.op)
            OP_AM: begin
                w_opa = r_acc_mul;
                w_opb = r_cur_mul;
            end
            OP_AA: begin
                w_opa    = r_acc_add;
                w_opb    = r_cur_mul;
                w_addend = r_cur_add;
            end
            OP_CA: begin
                w_opa = r_cur_mul + t_word'(1);
                w_opb = r_cur_add;
            end
            OP_CM: begin
                w_opa = r_cur_mul;
                w_opb = r_cur_mul;
            end
            OP_FIN: begin
                w_opa    = r_acc_mul;
                w_opb    = r_seed;
                w_addend = r_acc_add;
            end
            default: begin
                w_opa = r_acc_mul;
            end
        endcase
    end

    assign w_result = (w_opa * w_opb) + w_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_multiplier <= MULT_RESET;
            r_increment  <= INC_RESET;
        end else if (i_cfg.we) begin
            if (i_cfg.index == REG_MULTIPLIER) begin
                r_multiplier <= i_cfg.data;
            end else if (i_cfg.index == REG_INCREMENT) begin
                r_increment <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc_mul <= t_word'(1);
            r_acc_add <= '0;
            r_cur_mul <= r_multiplier;
            r_cur_add <= r_increment;
            r_k       <= i_step_count;
            r_seed    <= i_seed_in;
        end else begin
            case (i_cmd.op)
                OP_AM: begin
                    r_acc_mul <= w_result;
                end
                OP_AA: begin
                    r_acc_add <= w_result;
                end
                OP_CA: begin
                    r_cur_add <= w_result;
                end
                OP_CM: begin
                    r_cur_mul <= w_result;
                    r_k       <= {1'b0, r_k[WORD_W-1:1]};
                end
                OP_FIN: begin
                    r_seed_out <= w_result;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.k_zero     = (r_k == '0);
    assign o_sts.k_lsb      = r_k[0];
    assign o_sts.k_more     = |r_k[WORD_W-1:1];
    assign o_sts.k_next_lsb = r_k[1];
    assign o_seed_out       = r_seed_out;

endmodule

### hdl/lcg_jump_ahead.sv
`timescale 1ns / 1ps
// lcg_jump_ahead: advances a 32-bit lcg state by an arbitrary step count
// In one transaction a seed and a step count n come in, and one transaction with the state
// after n steps of x*a+c mod 2^32 goes out; a and c are config registers 0 and 1 (reset
// 214013 and 2531011, index beyond 1 ignored, write only while idle). The count is scanned
// lsb first on a single shared 32x32 multiplier: a load and a bit test, then for each bit
// up to the highest set one the accumulator updates (AM, AA) if it is set and an increment
// and a square step (CA, CM); a finish step writes the result when the output register is
// free. A new input is taken while the previous result still waits in the output register.

module lcg_jump_ahead (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcgja_in_if.sink    i_in,
    lcgja_out_if.source o_out,
    lcgja_cfg_if.sink   i_cfg
);
    import lcgja_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_cfg_wr w_cfg;

    assign i_cfg.ready = 1'b1;
    assign w_cfg.we    = i_cfg.valid;
    assign w_cfg.index = i_cfg.index;
    assign w_cfg.data  = i_cfg.data;

    lcgja_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    lcgja_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_seed_in    (i_in.seed_in),
        .i_step_count (i_in.step_count),
        .o_seed_out   (o_out.seed_out)
    );

`ifndef SYNTHESIS
    a_fin_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_FIN) |-> (!o_out.valid || o_out.ready))
        else $error("result written while output register still full");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready right after an accepted transaction");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.op == OP_FIN))
        else $error("output valid raised without a finish step");

    a_load_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (i_in.valid && i_in.ready && w_cmd.op == OP_NONE))
        else $error("datapath load without an input transaction");
`endif

endmodule
